// File: hdl/scs_pkg.sv
// Shared types and constants for the stick calibration scaler.
// No dependencies; imported by every module under hdl/.
`default_nettype none

package scs_pkg;

  localparam int unsigned SAMPLE_W = 12;  // raw sample and calibration width
  localparam int unsigned FRAC_W   = 15;  // full scale is 2**FRAC_W - 1
  localparam int unsigned NUM_W    = SAMPLE_W + FRAC_W;  // diff * full scale
  localparam int unsigned QUOT_W   = FRAC_W + 1;  // top bit flags overflow
  localparam int unsigned RES_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_X_CENTER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_SPAN_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_SPAN_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_CENTER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SPAN_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SPAN_LOW  = 3'd5;

  localparam logic [SAMPLE_W-1:0] CENTER_RESET = 12'd2048;
  localparam logic [SAMPLE_W-1:0] SPAN_RESET   = 12'd1024;

  localparam logic [FRAC_W-1:0] FULL_SCALE = {FRAC_W{1'b1}};

  // One item of one axis as it walks down the divider cells.
  typedef struct packed {
    logic                valid;
    logic                neg;    // sample at or below center
    logic                zero;   // lower branch with zero span: force 0
    logic [SAMPLE_W-1:0] span;
    logic [NUM_W-1:0]    rem;
    logic [QUOT_W-1:0]   quot;
  } cell_t;

endpackage

`default_nettype wire

// File: hdl/scs_prep.sv
// Front stage of one axis: picks the branch, forms |val-center| * full scale.
// Depends on scs_pkg.
`default_nettype none

module scs_prep
  import scs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [SAMPLE_W-1:0] val,
  input  wire logic [SAMPLE_W-1:0] center,
  input  wire logic [SAMPLE_W-1:0] span_high,
  input  wire logic [SAMPLE_W-1:0] span_low,
  output cell_t                    q
);

  logic                above;
  logic [SAMPLE_W-1:0] diff;
  cell_t               q_next;

  always_comb begin
    above  = val > center;
    diff   = above ? (val - center) : (center - val);
    q_next.valid = in_valid;
    q_next.neg   = !above;
    q_next.zero  = !above && (span_low == '0);
    q_next.span  = above ? span_high : span_low;
    // diff * (2**FRAC_W - 1) as a shift and subtract
    q_next.rem   = {diff, {FRAC_W{1'b0}}} - {{FRAC_W{1'b0}}, diff};
    q_next.quot  = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/scs_div_cell.sv
// One restoring-division cell: settles quotient bit BIT and hands on.
// Depends on scs_pkg.
`default_nettype none

module scs_div_cell
  import scs_pkg::*;
#(
  parameter int unsigned BIT = 0
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire cell_t d,
  output cell_t      q
);

  logic [NUM_W-1:0] trial;
  cell_t            q_next;

  always_comb begin
    trial  = {{(NUM_W-SAMPLE_W){1'b0}}, d.span} << BIT;
    q_next = d;
    if (d.rem >= trial) begin
      q_next.rem       = d.rem - trial;
      q_next.quot[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/stick_calibration_scaler.sv
// Top level of the stick calibration scaler: calibration registers,
// per-axis prep stage, divider cell chains, output register with skid.
// Depends on scs_pkg, scs_prep, scs_div_cell.
//
//   Channel   Dir  Handshake          Payload
//   s_*       in   tvalid/tready      tdata[23:0]  = raw_x, raw_y
//   m_*       out  tvalid/tready      tdata[31:0]  = scaled_x, scaled_y
//   cfg_*     in   cfg_we             cfg_index[2:0], cfg_wdata[11:0]
//
// An accepted item passes 1 prep stage, 16 divider cells and 1 output
// register; one item per cycle sustained while the skid slot is empty.
// The 16-cell restoring divider chain per axis sets the latency: each cell
// resolves one quotient bit, the top one flagging overflow into the clamp.
// Reset (rst, synchronous) empties the pipeline and loads calibration
// defaults (center 2048, spans 1024).
// The whole chain stalls only while the skid register is full; s_tready
// follows the skid flag register, so a result may wait at the output while
// new items enter.
`default_nettype none

module stick_calibration_scaler
  import scs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [23:0]          s_tdata,   // [11:0] raw_x, [23:12] raw_y
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [31:0]               m_tdata,   // [15:0] scaled_x, [31:16] scaled_y
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SAMPLE_W-1:0]  cfg_wdata
);

  // Calibration registers
  logic [SAMPLE_W-1:0] x_center, x_span_high, x_span_low;
  logic [SAMPLE_W-1:0] y_center, y_span_high, y_span_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_center    <= CENTER_RESET;
      x_span_high <= SPAN_RESET;
      x_span_low  <= SPAN_RESET;
      y_center    <= CENTER_RESET;
      y_span_high <= SPAN_RESET;
      y_span_low  <= SPAN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_CENTER:    x_center    <= cfg_wdata;
        REG_X_SPAN_HIGH: x_span_high <= cfg_wdata;
        REG_X_SPAN_LOW:  x_span_low  <= cfg_wdata;
        REG_Y_CENTER:    y_center    <= cfg_wdata;
        REG_Y_SPAN_HIGH: y_span_high <= cfg_wdata;
        REG_Y_SPAN_LOW:  y_span_low  <= cfg_wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Pipeline advance: hold everything only while the skid slot is occupied.
  logic skid_full;
  logic run;

  assign run      = !skid_full;
  assign s_tready = run;

  // Cell chains, one per axis; stage 0 is the prep register.
  cell_t chain_x [0:QUOT_W];
  cell_t chain_y [0:QUOT_W];

  scs_prep u_prep_x (
    .clk, .rst, .en(run), .in_valid(s_tvalid),
    .val(s_tdata[SAMPLE_W-1:0]), .center(x_center),
    .span_high(x_span_high), .span_low(x_span_low), .q(chain_x[0])
  );

  scs_prep u_prep_y (
    .clk, .rst, .en(run), .in_valid(s_tvalid),
    .val(s_tdata[2*SAMPLE_W-1:SAMPLE_W]), .center(y_center),
    .span_high(y_span_high), .span_low(y_span_low), .q(chain_y[0])
  );

  // Cell i settles quotient bit QUOT_W-1-i, most significant first.
  for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
    scs_div_cell #(.BIT(QUOT_W - 1 - i)) u_cell_x (
      .clk, .rst, .en(run), .d(chain_x[i]), .q(chain_x[i+1])
    );
    scs_div_cell #(.BIT(QUOT_W - 1 - i)) u_cell_y (
      .clk, .rst, .en(run), .d(chain_y[i]), .q(chain_y[i+1])
    );
  end

  // Finish: clamp on overflow bit, force zero, apply sign.
  function automatic logic [RES_W-1:0] finish(cell_t c);
    logic [FRAC_W-1:0] mag;
    logic [RES_W-1:0]  pos;
    mag = c.quot[QUOT_W-1] ? FULL_SCALE : c.quot[FRAC_W-1:0];
    pos = {{(RES_W-FRAC_W){1'b0}}, mag};
    if (c.zero) begin
      return '0;
    end
    return c.neg ? (~pos + 1'b1) : pos;
  endfunction

  logic        done;
  logic [31:0] done_data;
  logic [31:0] skid_data;
  logic        take;

  assign done      = chain_x[QUOT_W].valid && run;
  assign done_data = {finish(chain_y[QUOT_W]), finish(chain_x[QUOT_W])};
  assign take      = m_tvalid && m_tready;

  // Output register with one skid slot behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (take) begin
        skid_full <= 1'b0;
      end
    end else if (done) begin
      if (!m_tvalid || take) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (take) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (take) begin
        m_tdata <= skid_data;
      end
    end else if (done) begin
      if (!m_tvalid || take) begin
        m_tdata <= done_data;
      end else begin
        skid_data <= done_data;
      end
    end
  end

  // A parked item always has a visible item ahead of it.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> m_tvalid)
    else $error("skid holds an item while output is empty");

  // The skid slot fills only when the output was stalled.
  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(m_tvalid && !m_tready))
    else $error("skid filled without an output stall");

  // Clamp keeps both results inside +-full scale.
  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000))
    else $error("result outside full scale");

  // Both axis chains carry items in lockstep.
  a_axes_aligned: assert property (@(posedge clk) disable iff (rst)
    chain_x[QUOT_W].valid == chain_y[QUOT_W].valid)
    else $error("axis chains out of step");

endmodule

`default_nettype wire

// File: tb/scaler_checker.sv
// Checker for the stick calibration scaler: watches the sample, result and
// calibration ports, predicts each result and compares it field by field.
// Depends on scs_pkg for widths, register indexes and the full-scale constant.
module scaler_checker
  import scs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [23:0]          s_tdata,   // [11:0] raw_x, [23:12] raw_y
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [31:0]          m_tdata,   // [15:0] scaled_x, [31:16] scaled_y
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_wdata,
  output int                   mismatches,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [RES_W-1:0] x;
    logic signed [RES_W-1:0] y;
  } deflection_t;

  logic [SAMPLE_W-1:0] x_mid = CENTER_RESET;
  logic [SAMPLE_W-1:0] x_up = SPAN_RESET;
  logic [SAMPLE_W-1:0] x_down = SPAN_RESET;
  logic [SAMPLE_W-1:0] y_mid = CENTER_RESET;
  logic [SAMPLE_W-1:0] y_up = SPAN_RESET;
  logic [SAMPLE_W-1:0] y_down = SPAN_RESET;

  deflection_t expected_deflections[$];
  int error_count = 0;

  // Signed deflection of one axis; clamp to full scale; a zero upper span saturates, a zero lower span reads zero.
  function automatic logic signed [RES_W-1:0] predict_deflection(
    input logic [SAMPLE_W-1:0] sample,
    input logic [SAMPLE_W-1:0] mid,
    input logic [SAMPLE_W-1:0] up,
    input logic [SAMPLE_W-1:0] down
  );
    logic [31:0] quotient;
    if (sample > mid) begin
      if (up == '0) return RES_W'(FULL_SCALE);
      quotient = ((32'(sample) - 32'(mid)) * 32'(FULL_SCALE)) / 32'(up);
      if (quotient > 32'(FULL_SCALE)) quotient = 32'(FULL_SCALE);
      return $signed(quotient[RES_W-1:0]);
    end
    if (down == '0) return '0;
    quotient = ((32'(mid) - 32'(sample)) * 32'(FULL_SCALE)) / 32'(down);
    if (quotient > 32'(FULL_SCALE)) quotient = 32'(FULL_SCALE);
    return -$signed(quotient[RES_W-1:0]);
  endfunction

  always @(posedge clk) begin : monitor
    deflection_t got;
    deflection_t want;
    if (rst) begin
      x_mid = CENTER_RESET;
      x_up = SPAN_RESET;
      x_down = SPAN_RESET;
      y_mid = CENTER_RESET;
      y_up = SPAN_RESET;
      y_down = SPAN_RESET;
      expected_deflections.delete();
    end else begin
      // Retire results before taking new samples: none can match one just in.
      if (m_tvalid && m_tready) begin
        got.x = m_tdata[15:0];
        got.y = m_tdata[31:16];
        if (expected_deflections.size() == 0) begin
          $error("scaled_x/scaled_y: result with no sample pending, got %0d / %0d",
                 got.x, got.y);
          error_count++;
        end else begin
          want = expected_deflections.pop_front();
          if (got.x !== want.x) begin
            $error("scaled_x mismatch: expected %0d, actual %0d", want.x, got.x);
            error_count++;
          end
          if (got.y !== want.y) begin
            $error("scaled_y mismatch: expected %0d, actual %0d", want.y, got.y);
            error_count++;
          end
        end
      end
      // Predict with the calibration in force before any write at this edge.
      if (s_tvalid && s_tready) begin
        want.x = predict_deflection(s_tdata[11:0], x_mid, x_up, x_down);
        want.y = predict_deflection(s_tdata[23:12], y_mid, y_up, y_down);
        expected_deflections.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_X_CENTER:    x_mid = cfg_wdata;
          REG_X_SPAN_HIGH: x_up = cfg_wdata;
          REG_X_SPAN_LOW:  x_down = cfg_wdata;
          REG_Y_CENTER:    y_mid = cfg_wdata;
          REG_Y_SPAN_HIGH: y_up = cfg_wdata;
          REG_Y_SPAN_LOW:  y_down = cfg_wdata;
          default: ;
        endcase
      end
    end
    mismatches <= error_count;
    outstanding <= expected_deflections.size();
  end

endmodule

// File: tb/testbench.sv
// Top of the stick calibration scaler testbench: clock, reset, sample and
// calibration stimulus, result back-pressure and the final verdict.
// Depends on scs_pkg, stick_calibration_scaler and scaler_checker.
module testbench
  import scs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 200000;       // cycles; a correct run needs far fewer
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES = 300;    // long output stall for the pressure phase
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 76;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [23:0]          s_tdata = '0;      // [11:0] raw_x, [23:12] raw_y
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;           // [15:0] scaled_x, [31:16] scaled_y
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SAMPLE_W-1:0]  cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int stall_pct = 0;
  int holds_requested = 0;
  int holds_served = 0;

  // Calibration as last written, used to aim random samples near the edges.
  logic [SAMPLE_W-1:0] x_mid = CENTER_RESET;
  logic [SAMPLE_W-1:0] x_up = SPAN_RESET;
  logic [SAMPLE_W-1:0] x_down = SPAN_RESET;
  logic [SAMPLE_W-1:0] y_mid = CENTER_RESET;
  logic [SAMPLE_W-1:0] y_up = SPAN_RESET;
  logic [SAMPLE_W-1:0] y_down = SPAN_RESET;

  logic [23:0] sample_queue[$];

  stick_calibration_scaler uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  scaler_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stalls at the current rate; on request, hold off
  // for a long stretch so the pipeline fills and the input stalls.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_served != holds_requested) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Queue one sample pair, X in the low half.
  task automatic push_pair(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y);
    sample_queue.push_back({y, x});
  endtask

  // Offer every queued item in order, holding each until it is accepted.
  task automatic stream_samples(input int idle_pct);
    while (sample_queue.size() > 0) begin
      while ($urandom_range(99) < idle_pct) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= sample_queue.pop_front();
      do @(posedge clk); while (!s_tready);
    end
    s_tvalid <= 1'b0;
  endtask

  // Wait for every expected result, then let the pipeline run dry.
  task automatic settle_pipeline();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [SAMPLE_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
  endtask

  // Load a full calibration, plus junk to the unused indexes; block is idle.
  task automatic write_calibration(
    input logic [SAMPLE_W-1:0] xm, input logic [SAMPLE_W-1:0] xu,
    input logic [SAMPLE_W-1:0] xd, input logic [SAMPLE_W-1:0] ym,
    input logic [SAMPLE_W-1:0] yu, input logic [SAMPLE_W-1:0] yd
  );
    x_mid = xm;
    x_up = xu;
    x_down = xd;
    y_mid = ym;
    y_up = yu;
    y_down = yd;
    write_reg(REG_X_CENTER, xm);
    write_reg(REG_X_SPAN_HIGH, xu);
    write_reg(REG_X_SPAN_LOW, xd);
    write_reg(REG_Y_CENTER, ym);
    write_reg(REG_Y_SPAN_HIGH, yu);
    write_reg(REG_Y_SPAN_LOW, yd);
    write_reg(REG_SPARE_A, SAMPLE_W'($urandom));
    write_reg(REG_SPARE_B, SAMPLE_W'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mix of uniform samples, samples around the span edges (clamp region),
  // samples right at center, and the rails.
  function automatic logic [SAMPLE_W-1:0] random_sample(
    input logic [SAMPLE_W-1:0] mid, input logic [SAMPLE_W-1:0] up,
    input logic [SAMPLE_W-1:0] down
  );
    int v;
    case ($urandom_range(3))
      0: v = $urandom_range(4095);
      1: v = int'(mid) - int'(down) - 4 + int'($urandom_range(int'(up) + int'(down) + 8));
      2: v = int'(mid) - 1 + int'($urandom_range(2));
      default: v = $urandom_range(1) ? 4095 : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SAMPLE_W'(v);
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Reset calibration: rails, center and its neighbors, exact full scale
    // and one step past it on each side.
    push_pair(12'd0, 12'd4095);
    push_pair(12'd4095, 12'd0);
    push_pair(12'd2048, 12'd2048);
    push_pair(12'd2047, 12'd2049);
    push_pair(12'd2049, 12'd2047);
    push_pair(12'd3072, 12'd1024);
    push_pair(12'd3073, 12'd1023);
    push_pair(12'd1024, 12'd3072);
    push_pair(12'd1023, 12'd3073);
    stream_samples(0);
    settle_pipeline();

    // Zero spans: above center saturates high, at or below center reads zero.
    write_calibration(12'd2048, 12'd0, 12'd0, 12'd2048, 12'd0, 12'd0);
    push_pair(12'd2049, 12'd2048);
    push_pair(12'd2048, 12'd2049);
    push_pair(12'd0, 12'd4095);
    push_pair(12'd4095, 12'd0);
    stream_samples(0);
    settle_pipeline();

    // Center on the rails with the widest spans.
    write_calibration(12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
    push_pair(12'd0, 12'd4095);
    push_pair(12'd1, 12'd4094);
    push_pair(12'd4095, 12'd0);
    stream_samples(0);
    settle_pipeline();

    // Unit spans: any step off center clamps.
    write_calibration(12'd2000, 12'd1, 12'd1, 12'd100, 12'd1, 12'd1);
    push_pair(12'd2001, 12'd99);
    push_pair(12'd1999, 12'd101);
    push_pair(12'd2000, 12'd100);
    stream_samples(0);
    settle_pipeline();

    // Random phases: a fresh calibration each, cycling the traffic modes.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        1: write_calibration(12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        3: write_calibration(SAMPLE_W'($urandom), 12'd1, 12'd1,
                             SAMPLE_W'($urandom), 12'd1, 12'd1);
        4: write_calibration(SAMPLE_W'($urandom), 12'd0, 12'd0, SAMPLE_W'($urandom),
                             12'd0, SAMPLE_W'($urandom));
        6: write_calibration(12'd2048, 12'd4095, 12'd4095, 12'd2048, 12'd4095, 12'd4095);
        7: write_calibration(SAMPLE_W'($urandom), SAMPLE_W'($urandom_range(40)),
                             SAMPLE_W'($urandom_range(40)), SAMPLE_W'($urandom),
                             SAMPLE_W'($urandom_range(40)), SAMPLE_W'($urandom_range(40)));
        default: write_calibration(SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                                   SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                                   SAMPLE_W'($urandom), SAMPLE_W'($urandom));
      endcase
      repeat (PHASE_ITEMS)
        push_pair(random_sample(x_mid, x_up, x_down), random_sample(y_mid, y_up, y_down));
      case (p % 4)
        0: begin
          stall_pct = 0;
          stream_samples(0);
        end
        1: begin
          stall_pct = 0;
          stream_samples(53);
        end
        2: begin
          stall_pct = 53;
          stream_samples(0);
        end
        default: begin
          stall_pct = 11;
          stream_samples(11);
        end
      endcase
      settle_pipeline();
    end

    // Pressure: stop the result side for a long stretch while samples keep
    // coming, so the pipeline fills up and backs up into the input.
    write_calibration(SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                      SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    stall_pct = 0;
    repeat (40)
      push_pair(random_sample(x_mid, x_up, x_down), random_sample(y_mid, y_up, y_down));
    holds_requested++;
    stream_samples(0);
    settle_pipeline();

    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
